// ===== src/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, register indexes and control types for the 64-bit
// Diffie-Hellman exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Fixed width of every payload field and configuration register.
  localparam int FIELD_W   = 64;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_GENERATOR = 2'd1,
    CFG_EXPONENT  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PUBLIC = 1'b0,
    FUNC_SHARED = 1'b1
  } func_e;

  // Command from the sequencer to the modular multiplier.
  typedef struct packed {
    logic start;
  } mm_ctl_t;

  // Status from the modular multiplier back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ===== src/modexp_intf.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface modexp_req_if import modexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] peer_value;

  modport source (output valid, output func, output peer_value, input ready);
  modport sink   (input valid, input func, input peer_value, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] key_value;
  logic               operand_error;

  modport source (output valid, output key_value, output operand_error, input ready);
  modport sink   (input valid, input key_value, input operand_error, output ready);
endinterface

interface modexp_cfg_if import modexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes (a * b) mod p by add-and-double, one bit of b per cycle, LSB first.
// Intermediate values never exceed the modulus, so no wide product is formed.
// ----------------------------------------------------------------------------
module modexp_mulmod import modexp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mm_ctl_t              ctl_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] p_i,
  output mm_stat_t             stat_o,
  output logic [WORD_BITS-1:0] result_o
);

  localparam int                CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0]  STEPS = CNT_W'(WORD_BITS);

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] b_q;
  logic [WORD_BITS-1:0] gap;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // Adding a is done as subtracting p - a whenever the sum would reach p.
  always_comb begin
    gap = p_i - a_q;
    if (b_q[0]) begin
      if (acc_q >= gap) begin
        acc_d = acc_q - gap;
      end else begin
        acc_d = acc_q + a_q;
      end
    end else begin
      acc_d = acc_q;
    end
    if (a_q >= gap) begin
      a_d = a_q - gap;
    end else begin
      a_d = {a_q[WORD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_d;
      b_q   <= b_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = acc_q;

`ifndef SYNTHESIS
  a_acc_below_p : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_q < p_i) else $error("accumulator reached the modulus");
  a_dbl_below_p : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> a_q < p_i) else $error("doubled operand reached the modulus");
  a_no_restart  : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("multiplier started while busy");
`endif

endmodule

// ===== src/modular_exponentiation_64_top.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation, 64-bit Diffie-Hellman
// Raises a base to the configured private exponent modulo the configured
// modulus, by square-and-multiply over a shared add-and-double multiplier.
// ----------------------------------------------------------------------------
// Each request transaction yields one response transaction. Func 0 takes the
// configured generator as the base (public key), func 1 takes peer_value
// (shared secret). A base not below the modulus, or a modulus below 2, gives
// key_value zero with operand_error set; the request goes straight to FINISH,
// which loads the response register. Otherwise the exponent is scanned from
// its top bit down: each bit costs one modular squaring plus one modular
// multiplication when the bit is set, all in the single shared multiplier.
// The block takes one request at a time; a finished result sits in the
// response register, and the next request is taken while it waits.
// Registers are to be written by the user through the configuration
// channel only while the block is idle; the block itself does not
// enforce this.
module modular_exponentiation_64_top import modexp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  modexp_cfg_if.sink   cfg_i,
  modexp_req_if.sink   req_i,
  modexp_rsp_if.source rsp_o
);

  localparam int BIT_W = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    IDLE,
    SQR_START,
    SQR_WAIT,
    MUL_START,
    MUL_WAIT,
    FINISH
  } state_e;

  state_e               state_q;
  logic [FIELD_W-1:0]   modulus_q;
  logic [FIELD_W-1:0]   generator_q;
  logic [FIELD_W-1:0]   exponent_q;
  logic [WORD_BITS-1:0] p_q;
  logic [WORD_BITS-1:0] exp_q;
  logic [WORD_BITS-1:0] base_q;
  logic [WORD_BITS-1:0] r_q;
  logic [BIT_W-1:0]     bit_q;
  logic                 err_q;
  logic                 rsp_valid_q;
  logic [FIELD_W-1:0]   rsp_key_q;
  logic                 rsp_err_q;

  logic [WORD_BITS-1:0] req_base;
  logic [WORD_BITS-1:0] cfg_p;
  logic                 req_err;
  logic                 req_fire;
  logic                 last_bit;
  logic                 rsp_load;
  mm_ctl_t              mm_ctl;
  mm_stat_t             mm_stat;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_result;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= '0;
      generator_q <= '0;
      exponent_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODULUS:   modulus_q   <= cfg_i.data;
        CFG_GENERATOR: generator_q <= cfg_i.data;
        CFG_EXPONENT:  exponent_q  <= cfg_i.data;
        default:       ;
      endcase
    end
  end

  // Operand check at acceptance.
  assign cfg_p    = modulus_q[WORD_BITS-1:0];
  assign req_base = (req_i.func == FUNC_SHARED) ? req_i.peer_value[WORD_BITS-1:0]
                                                : generator_q[WORD_BITS-1:0];
  assign req_err  = (cfg_p < WORD_BITS'(2)) || (req_base >= cfg_p);

  assign req_i.ready = (state_q == IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign last_bit    = (bit_q == '0);

  // The response register is free, or is emptied in this cycle.
  assign rsp_load = (state_q == FINISH) && (!rsp_valid_q || rsp_o.ready);

  assign mm_ctl.start = (state_q == SQR_START) || (state_q == MUL_START);
  assign mm_b         = (state_q == MUL_START) ? base_q : r_q;

  modexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mm_ctl),
    .a_i      (r_q),
    .b_i      (mm_b),
    .p_i      (p_q),
    .stat_o   (mm_stat),
    .result_o (mm_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      p_q         <= '0;
      exp_q       <= '0;
      base_q      <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      err_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_key_q   <= '0;
      rsp_err_q   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (req_fire) begin
            p_q    <= cfg_p;
            exp_q  <= exponent_q[WORD_BITS-1:0];
            base_q <= req_base;
            bit_q  <= BIT_W'(WORD_BITS - 1);
            err_q  <= req_err;
            if (req_err) begin
              r_q     <= '0;
              state_q <= FINISH;
            end else begin
              r_q     <= WORD_BITS'(1);
              state_q <= SQR_START;
            end
          end
        end
        SQR_START: state_q <= SQR_WAIT;
        MUL_START: state_q <= MUL_WAIT;
        SQR_WAIT, MUL_WAIT: begin
          if (mm_stat.done) begin
            r_q <= mm_result;
            if ((state_q == SQR_WAIT) && exp_q[bit_q]) begin
              state_q <= MUL_START;
            end else if (last_bit) begin
              state_q <= FINISH;
            end else begin
              bit_q   <= bit_q - 1'b1;
              state_q <= SQR_START;
            end
          end
        end
        FINISH: begin
          if (rsp_load) begin
            rsp_key_q <= FIELD_W'(r_q);
            rsp_err_q <= err_q;
            state_q   <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.key_value     = rsp_key_q;
  assign rsp_o.operand_error = rsp_err_q;

`ifndef SYNTHESIS
  a_err_zero_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_err_q) |-> (rsp_key_q == '0))
    else $error("operand error response carries a nonzero key");
  a_busy_after   : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != IDLE)) else $error("request accepted but no work started");
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_stat.done |-> (state_q == SQR_WAIT || state_q == MUL_WAIT))
    else $error("product finished outside a wait state");
  a_result_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_stat.done |-> (mm_result < p_q)) else $error("product not reduced");
`endif

endmodule
